// ===== src/sbfa_pkg.sv =====
// Shared types and constants for the status byte frame assembler.
// Used by sbfa_ctrl, sbfa_datapath and status_byte_frame_assembler; no dependencies.
package sbfa_pkg;

    localparam int unsigned MAX_FRAME_BYTES_DEF = 31;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned HEADER_BIT  = 7;

    // Frame lengths, in bytes, selected by the header byte.
    localparam int unsigned LEN_MODULE = 31;
    localparam int unsigned LEN_MASTER = 7;
    localparam int unsigned LEN_OTHER  = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_MODULE_SETUP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MASTER_SETUP = 2'd1;

    localparam logic [BYTE_W-1:0] MODULE_SETUP_RESET = 8'd128;
    localparam logic [BYTE_W-1:0] MASTER_SETUP_RESET = 8'd129;

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } sbfa_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic accept;   // input transaction this cycle
        logic load;     // move the next stored byte into the output register
    } sbfa_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic frame_done;   // the byte now offered completes a frame
        logic load_last;    // the next load moves the final frame byte
        logic out_valid;    // output register holds a byte not yet taken
    } sbfa_status_t;

endpackage

// ===== src/sbfa_ctrl.sv =====
// Controller state machine of the status byte frame assembler.
// Depends on sbfa_pkg for the state type and the command and status structs.
module sbfa_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  m_tready,
    input  sbfa_pkg::sbfa_status_t status,
    output sbfa_pkg::sbfa_cmd_t    cmd
);
    import sbfa_pkg::*;

    sbfa_state_t state_reg;
    sbfa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.load   = 1'b0;
        case (state_reg)
            ST_COLLECT: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && status.frame_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Refill the output register whenever it is empty or being drained.
                cmd.load = !status.out_valid || m_tready;
                if (cmd.load && status.load_last) begin
                    state_next = ST_COLLECT;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

endmodule

// ===== src/sbfa_datapath.sv =====
// Datapath of the status byte frame assembler: configuration registers,
// frame store, byte counters and output register. Depends on sbfa_pkg.
module sbfa_datapath #(
    parameter int unsigned MAX_FRAME_BYTES = sbfa_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [sbfa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sbfa_pkg::BYTE_W-1:0]       cfg_data,
    input  logic [sbfa_pkg::BYTE_W-1:0]       s_tdata,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [sbfa_pkg::BYTE_W-1:0]       m_tdata,
    output logic                              m_tlast,
    input  sbfa_pkg::sbfa_cmd_t               cmd,
    output sbfa_pkg::sbfa_status_t            status
);
    import sbfa_pkg::*;

    localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned AW = $clog2(MAX_FRAME_BYTES);

    localparam int unsigned LEN_MOD_SAT =
        (LEN_MODULE > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : LEN_MODULE;
    localparam int unsigned LEN_MAS_SAT =
        (LEN_MASTER > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : LEN_MASTER;
    localparam int unsigned LEN_OTH_SAT =
        (LEN_OTHER > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : LEN_OTHER;

    localparam logic [CW-1:0] DEPTH = CW'(MAX_FRAME_BYTES);

    logic [BYTE_W-1:0] module_code_reg;
    logic [BYTE_W-1:0] master_code_reg;

    logic [BYTE_W-1:0] store_mem [MAX_FRAME_BYTES];

    logic [CW-1:0]     byte_count_reg,   byte_count_next;
    logic [CW-1:0]     frame_length_reg, frame_length_next;
    logic              in_frame_reg,     in_frame_next;
    logic [CW-1:0]     rd_idx_reg,       rd_idx_next;
    logic              out_valid_reg,    out_valid_next;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_last_reg;

    logic              is_header;
    logic              open_after;
    logic [CW-1:0]     count_base;
    logic [CW-1:0]     count_after;
    logic [CW-1:0]     len_pick;
    logic [CW-1:0]     len_sel;
    logic              wr_en;
    logic [CW-1:0]     rd_idx_inc;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            module_code_reg <= MODULE_SETUP_RESET;
            master_code_reg <= MASTER_SETUP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MODULE_SETUP: module_code_reg <= cfg_data;
                REG_MASTER_SETUP: master_code_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The module setup code wins when both codes are equal.
    always_comb begin
        if (s_tdata == module_code_reg) begin
            len_pick = CW'(LEN_MOD_SAT);
        end else if (s_tdata == master_code_reg) begin
            len_pick = CW'(LEN_MAS_SAT);
        end else begin
            len_pick = CW'(LEN_OTH_SAT);
        end
    end

    assign is_header   = s_tdata[HEADER_BIT];
    assign open_after  = is_header || in_frame_reg;
    assign count_base  = is_header ? '0 : byte_count_reg;
    assign len_sel     = is_header ? len_pick : frame_length_reg;
    assign wr_en       = open_after && (count_base < DEPTH);
    assign count_after = count_base + CW'(wr_en);
    assign rd_idx_inc  = rd_idx_reg + CW'(1);

    assign status.frame_done = open_after && (count_after >= len_sel);
    assign status.load_last  = (rd_idx_inc == frame_length_reg);
    assign status.out_valid  = out_valid_reg;

    always_comb begin
        byte_count_next   = byte_count_reg;
        frame_length_next = frame_length_reg;
        in_frame_next     = in_frame_reg;
        rd_idx_next       = rd_idx_reg;
        out_valid_next    = out_valid_reg;
        if (cmd.accept) begin
            // The replay index restarts whenever the frame length may change.
            frame_length_next = len_sel;
            rd_idx_next       = '0;
            if (status.frame_done) begin
                byte_count_next = '0;
                in_frame_next   = 1'b0;
            end else begin
                byte_count_next = open_after ? count_after : byte_count_reg;
                in_frame_next   = open_after;
            end
        end
        if (cmd.load) begin
            rd_idx_next    = rd_idx_inc;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg   <= '0;
            frame_length_reg <= '0;
            in_frame_reg     <= 1'b0;
            rd_idx_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            byte_count_reg   <= byte_count_next;
            frame_length_reg <= frame_length_next;
            in_frame_reg     <= in_frame_next;
            rd_idx_reg       <= rd_idx_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Frame store: one write port, one registered read port feeding the output.
    always_ff @(posedge aclk) begin
        if (cmd.accept && wr_en) begin
            store_mem[count_base[AW-1:0]] <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_data_reg <= store_mem[rd_idx_reg[AW-1:0]];
            out_last_reg <= status.load_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // An open frame always has room for at least one more byte before completing.
    a_open_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        in_frame_reg |-> (byte_count_reg < frame_length_reg))
        else $error("open frame count reached its length");

    // No partial count survives outside a frame.
    a_closed_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> (byte_count_reg == '0))
        else $error("byte count nonzero outside a frame");

    // Replay never walks past the stored frame.
    a_rd_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_idx_reg <= frame_length_reg)
        else $error("replay index beyond frame length");

    // A load always fills the output register on the next cycle.
    a_load_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> out_valid_reg)
        else $error("load did not fill output register");

endmodule

// ===== src/status_byte_frame_assembler.sv =====
// Top level of the status byte frame assembler: ties the controller to the datapath.
// Depends on sbfa_pkg, sbfa_ctrl and sbfa_datapath.
//
//  Channel   Direction  Handshake              Contents
//  s_        in         s_tvalid / s_tready    s_tdata[7:0] = rx_byte
//  m_        out        m_tvalid / m_tready    m_tdata[7:0] = frame_byte, m_tlast = frame_last
//  cfg_      in         cfg_valid / cfg_ready  cfg_index = register, cfg_data = value
//
// While a frame is collected, one input transaction is taken every cycle.
// A byte that completes a frame is followed by an emission phase of one cycle per frame
// byte (up to 31 with the default store) while m_tready stays high; the single read port
// of the frame store sets this pace. s_tready is low during emission and rises once the
// final byte has entered the output register, which may still be waiting to be taken.
// Reset is synchronous on aresetn low; no clearing pass is needed after it.
// A stall on m_tready holds the output register and pauses the replay.
module status_byte_frame_assembler #(
    parameter int unsigned MAX_FRAME_BYTES = sbfa_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input byte stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sbfa_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] rx_byte
    // Frame byte stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sbfa_pkg::BYTE_W-1:0]       m_tdata,   // [7:0] frame_byte
    output logic                              m_tlast,   // frame_last
    // Configuration writes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sbfa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sbfa_pkg::BYTE_W-1:0]       cfg_data
);
    import sbfa_pkg::*;

    sbfa_cmd_t    cmd;
    sbfa_status_t status;

    // Configuration writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    // The controller decides when a byte is taken and when stored bytes are replayed.
    sbfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the codes, the frame store, the counters and the output register.
    sbfa_datapath #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
